[src/tcp_pkg.sv]
// ----------------------------------------------------------------------------
// tcp_pkg
// Shared widths, types and helpers for the triangle closest-point pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package tcp_pkg;

  localparam int CW        = 16;               // coordinate width
  localparam int DW        = CW + 1;           // vertex difference
  localparam int NRAW_W    = 2 * DW + 1;       // raw plane normal component
  localparam int NORM_BITS = (59 - CW) / 2;    // normal is scaled to this many bits
  localparam int NN_W      = NORM_BITS + 1;    // scaled normal component
  localparam int S_W       = NN_W + DW + 2;    // dot(N, P-A)
  localparam int N2_W      = 2 * NORM_BITS + 2;// |N|^2
  localparam int ED_W      = 2 * DW + 2;       // edge dot(w, l)
  localparam int EQ_W      = 2 * DW;           // edge dot(l, l)
  localparam int DN_W      = 62;               // divider dividend magnitude
  localparam int DD_W      = N2_W;             // divider divisor
  localparam int DQ_BITS   = DW + 1;           // quotient magnitude bits, one per stage
  localparam int Q_W       = DQ_BITS + 1;      // signed quotient
  localparam int PT_W      = CW + 4;           // projected / edge point
  localparam int TD_W      = PT_W + 1;         // vertex minus point
  localparam int XRAW_W    = 2 * TD_W + 1;     // raw barycentric cross product
  localparam int XFIT_BITS = 30;
  localparam int XN_W      = XFIT_BITS + 1;
  localparam int XP_W      = 2 * XN_W;
  localparam int XS_W      = XP_W + 2;
  localparam int MD_W      = 2 * TD_W + 2;     // squared distance
  localparam int SH_W      = 7;                // normalizing shift amount

  localparam int FRONT_DEPTH = 6;
  localparam int BACK_DEPTH  = 6;
  localparam int PIPE_DEPTH  = FRONT_DEPTH + DQ_BITS + BACK_DEPTH;

  // point slots inside pts_t
  localparam int PA = 0;
  localparam int PB = 1;
  localparam int PC = 2;
  localparam int PP = 3;

  typedef logic [3:0][2:0][CW-1:0] pts_t;

  typedef enum logic [1:0] {
    REG_INTERIOR = 2'd0,
    REG_AB       = 2'd1,
    REG_BC       = 2'd2,
    REG_CA       = 2'd3
  } region_t;

  typedef struct packed {
    logic [2:0][2:0][DN_W-1:0] em;    // edge dividend magnitudes
    logic [2:0][2:0]           eneg;
    logic [2:0][EQ_W-1:0]      eq;    // edge divisors
    logic [2:0][DN_W-1:0]      pm;    // projection dividend magnitudes
    logic [2:0]                pneg;
    logic [N2_W-1:0]           n2;    // projection divisor
  } div_in_t;

  typedef struct packed {
    pts_t       pts;
    logic       nzero;                // degenerate triangle
    logic [2:0] sel_s;                // edge point is the start vertex
    logic [2:0] sel_e;                // edge point is the end vertex
  } side_t;

  typedef struct packed {
    logic [2:0][CW-1:0] pt;
    region_t            region;
  } result_t;

  function automatic logic [63:0] mag64(input logic signed [63:0] x);
    return x[63] ? 64'(-x) : 64'(x);
  endfunction

  // shift that brings a magnitude below 2^bits
  function automatic logic [SH_W-1:0] fit_shift(input logic [63:0] mag, input int bits);
    logic [SH_W-1:0] len;
    len = '0;
    for (int i = 0; i < 64; i++) begin
      if (mag[i]) len = SH_W'(i + 1);
    end
    return (int'(len) > bits) ? SH_W'(int'(len) - bits) : '0;
  endfunction

  // shift toward zero
  function automatic logic signed [63:0] tshift(input logic signed [63:0] x,
                                                input logic [SH_W-1:0] k);
    logic [63:0] m;
    m = mag64(x) >> k;
    return x[63] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [CW-1:0] sat_coord(input logic signed [PT_W-1:0] v);
    logic signed [PT_W-1:0] hi;
    logic signed [PT_W-1:0] lo;
    hi = PT_W'((64'sd1 <<< (CW - 1)) - 64'sd1);
    lo = -hi - PT_W'(1);
    if (v > hi) return CW'(hi);
    if (v < lo) return CW'(lo);
    return CW'(v);
  endfunction

endpackage

`default_nettype wire

[src/tcp_div.sv]
// ----------------------------------------------------------------------------
// tcp_div
// Pipelined restoring divider, one quotient bit per stage, truncating.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [tcp_pkg::DN_W-1:0]   num,
  input  logic [tcp_pkg::DD_W-1:0]   den,
  input  logic                       neg,
  output logic [tcp_pkg::Q_W-1:0]    quo
);

  localparam int DN_W = tcp_pkg::DN_W;
  localparam int DD_W = tcp_pkg::DD_W;
  localparam int QB   = tcp_pkg::DQ_BITS;
  localparam int Q_W  = tcp_pkg::Q_W;

  logic [DN_W-1:0] rem_r [QB];
  logic [DD_W-1:0] den_r [QB];
  logic [QB-1:0]   qb_r  [QB];
  logic            neg_r [QB];

  logic [DN_W-1:0] rem_i [QB];
  logic [DD_W-1:0] den_i [QB];
  logic [QB-1:0]   qb_i  [QB];
  logic            neg_i [QB];

  always_comb begin
    rem_i[0] = num;
    den_i[0] = den;
    qb_i[0]  = '0;
    neg_i[0] = neg;
    for (int j = 1; j < QB; j++) begin
      rem_i[j] = rem_r[j-1];
      den_i[j] = den_r[j-1];
      qb_i[j]  = qb_r[j-1];
      neg_i[j] = neg_r[j-1];
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_step
    logic [DN_W-1:0] dsh;
    logic            ge;

    assign dsh = DN_W'(den_i[j]) << (QB - 1 - j);
    assign ge  = rem_i[j] >= dsh;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= ge ? rem_i[j] - dsh : rem_i[j];
        den_r[j] <= den_i[j];
        qb_r[j]  <= {qb_i[j][QB-2:0], ge};
        neg_r[j] <= neg_i[j];
      end
    end
  end

  assign quo = neg_r[QB-1] ? Q_W'(-$signed({1'b0, qb_r[QB-1]}))
                           : Q_W'({1'b0, qb_r[QB-1]});

endmodule

`default_nettype wire

[src/tcp_front.sv]
// ----------------------------------------------------------------------------
// tcp_front
// Normal, projection numerators and edge parameters up to the dividers.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_front (
  input  logic             clk,
  input  logic             en,
  input  tcp_pkg::pts_t    pts,
  output tcp_pkg::div_in_t dvi,
  output tcp_pkg::side_t   side
);

  localparam int DW     = tcp_pkg::DW;
  localparam int NRAW_W = tcp_pkg::NRAW_W;
  localparam int NN_W   = tcp_pkg::NN_W;
  localparam int S_W    = tcp_pkg::S_W;
  localparam int N2_W   = tcp_pkg::N2_W;
  localparam int ED_W   = tcp_pkg::ED_W;
  localparam int EQ_W   = tcp_pkg::EQ_W;
  localparam int DN_W   = tcp_pkg::DN_W;
  localparam int SH_W   = tcp_pkg::SH_W;
  localparam int PW     = DW + ED_W;
  localparam int NP_W   = NN_W + S_W;

  // stage 1: differences
  logic [2:0][2:0][DW-1:0] el1_r, el1_nxt, ew1_r, ew1_nxt;
  logic [2:0][DW-1:0]      ac1_r, ac1_nxt;
  tcp_pkg::pts_t           pts1_r;
  // stage 2: raw normal, edge dots
  logic [2:0][NRAW_W-1:0]  nraw2_r, nraw2_nxt;
  logic [2:0][ED_W-1:0]    ed2_r, ed2_nxt;
  logic [2:0][EQ_W-1:0]    eq2_r, eq2_nxt;
  logic [2:0][2:0][DW-1:0] el2_r;
  logic [2:0][DW-1:0]      w2_r;
  tcp_pkg::pts_t           pts2_r;
  // stage 3: normal scale, edge decisions
  logic [SH_W-1:0]         nk3_r, nk3_nxt;
  logic                    nzero3_r, nzero3_nxt;
  logic [2:0]              sel_s3_r, sel_s3_nxt, sel_e3_r, sel_e3_nxt;
  logic [2:0][NRAW_W-1:0]  nraw3_r;
  logic [2:0][ED_W-1:0]    ed3_r;
  logic [2:0][EQ_W-1:0]    eq3_r;
  logic [2:0][2:0][DW-1:0] el3_r;
  logic [2:0][DW-1:0]      w3_r;
  tcp_pkg::pts_t           pts3_r;
  // stage 4: scaled normal, edge numerators
  logic [2:0][NN_W-1:0]    nn4_r, nn4_nxt;
  logic [2:0][2:0][DN_W-1:0] em4_r, em4_nxt;
  logic [2:0][2:0]         eneg4_r, eneg4_nxt;
  logic [2:0][EQ_W-1:0]    eq4_r;
  logic [2:0][DW-1:0]      w4_r;
  tcp_pkg::pts_t           pts4_r;
  logic                    nzero4_r;
  logic [2:0]              sel_s4_r, sel_e4_r;
  // stage 5: s and |N|^2
  logic [S_W-1:0]          s5_r, s5_nxt;
  logic [N2_W-1:0]         n2_5_r, n2_5_nxt;
  logic [2:0][NN_W-1:0]    nn5_r;
  logic [2:0][2:0][DN_W-1:0] em5_r;
  logic [2:0][2:0]         eneg5_r;
  logic [2:0][EQ_W-1:0]    eq5_r;
  tcp_pkg::pts_t           pts5_r;
  logic                    nzero5_r;
  logic [2:0]              sel_s5_r, sel_e5_r;
  // stage 6: projection numerators
  logic [2:0][DN_W-1:0]    pm6_r, pm6_nxt;
  logic [2:0]              pneg6_r, pneg6_nxt;
  logic [N2_W-1:0]         n2_6_r;
  logic [2:0][2:0][DN_W-1:0] em6_r;
  logic [2:0][2:0]         eneg6_r;
  logic [2:0][EQ_W-1:0]    eq6_r;
  tcp_pkg::pts_t           pts6_r;
  logic                    nzero6_r;
  logic [2:0]              sel_s6_r, sel_e6_r;

  always_comb begin
    int en_i;
    for (int e = 0; e < 3; e++) begin
      en_i = (e == 2) ? 0 : e + 1;
      for (int i = 0; i < 3; i++) begin
        el1_nxt[e][i] = DW'($signed(pts[en_i][i])) - DW'($signed(pts[e][i]));
        ew1_nxt[e][i] = DW'($signed(pts[tcp_pkg::PP][i])) - DW'($signed(pts[e][i]));
      end
    end
    for (int i = 0; i < 3; i++) begin
      ac1_nxt[i] = DW'($signed(pts[tcp_pkg::PC][i])) - DW'($signed(pts[tcp_pkg::PA][i]));
    end
  end

  always_comb begin
    int j;
    int k;
    logic signed [ED_W-1:0] accd;
    logic signed [ED_W-1:0] accq;
    for (int i = 0; i < 3; i++) begin
      j = (i == 2) ? 0 : i + 1;
      k = (i == 0) ? 2 : i - 1;
      nraw2_nxt[i] = NRAW_W'($signed(el1_r[0][j])) * NRAW_W'($signed(ac1_r[k]))
                   - NRAW_W'($signed(el1_r[0][k])) * NRAW_W'($signed(ac1_r[j]));
    end
    for (int e = 0; e < 3; e++) begin
      accd = '0;
      accq = '0;
      for (int i = 0; i < 3; i++) begin
        accd = accd + ED_W'($signed(ew1_r[e][i])) * ED_W'($signed(el1_r[e][i]));
        accq = accq + ED_W'($signed(el1_r[e][i])) * ED_W'($signed(el1_r[e][i]));
      end
      ed2_nxt[e] = accd;
      eq2_nxt[e] = EQ_W'(accq);
    end
  end

  always_comb begin
    logic [63:0] m;
    logic [63:0] mx;
    mx = '0;
    for (int i = 0; i < 3; i++) begin
      m = tcp_pkg::mag64(64'($signed(nraw2_r[i])));
      if (m > mx) mx = m;
    end
    nk3_nxt    = tcp_pkg::fit_shift(mx, tcp_pkg::NORM_BITS);
    nzero3_nxt = (mx == '0);
    for (int e = 0; e < 3; e++) begin
      sel_s3_nxt[e] = (eq2_r[e] == '0) || ($signed(ed2_r[e]) <= 0);
      sel_e3_nxt[e] = !sel_s3_nxt[e] && ($signed(ed2_r[e]) >= $signed(ED_W'(eq2_r[e])));
    end
  end

  always_comb begin
    logic signed [PW-1:0] p;
    for (int i = 0; i < 3; i++) begin
      nn4_nxt[i] = NN_W'(tcp_pkg::tshift(64'($signed(nraw3_r[i])), nk3_r));
    end
    for (int e = 0; e < 3; e++) begin
      for (int i = 0; i < 3; i++) begin
        p = PW'($signed(el3_r[e][i])) * PW'($signed(ed3_r[e]));
        em4_nxt[e][i]   = DN_W'(tcp_pkg::mag64(64'(p)));
        eneg4_nxt[e][i] = p[PW-1];
      end
    end
  end

  always_comb begin
    logic signed [S_W-1:0]  acc;
    logic signed [N2_W:0]   acc2;
    acc  = '0;
    acc2 = '0;
    for (int i = 0; i < 3; i++) begin
      acc  = acc + S_W'($signed(nn4_r[i])) * S_W'($signed(w4_r[i]));
      acc2 = acc2 + (N2_W+1)'($signed(nn4_r[i])) * (N2_W+1)'($signed(nn4_r[i]));
    end
    s5_nxt   = acc;
    n2_5_nxt = N2_W'(acc2);
  end

  always_comb begin
    logic signed [NP_W-1:0] p;
    for (int i = 0; i < 3; i++) begin
      p = NP_W'($signed(nn5_r[i])) * NP_W'($signed(s5_r));
      pm6_nxt[i]   = DN_W'(tcp_pkg::mag64(64'(p)));
      pneg6_nxt[i] = p[NP_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      el1_r    <= el1_nxt;
      ew1_r    <= ew1_nxt;
      ac1_r    <= ac1_nxt;
      pts1_r   <= pts;

      nraw2_r  <= nraw2_nxt;
      ed2_r    <= ed2_nxt;
      eq2_r    <= eq2_nxt;
      el2_r    <= el1_r;
      w2_r     <= ew1_r[0];
      pts2_r   <= pts1_r;

      nk3_r    <= nk3_nxt;
      nzero3_r <= nzero3_nxt;
      sel_s3_r <= sel_s3_nxt;
      sel_e3_r <= sel_e3_nxt;
      nraw3_r  <= nraw2_r;
      ed3_r    <= ed2_r;
      eq3_r    <= eq2_r;
      el3_r    <= el2_r;
      w3_r     <= w2_r;
      pts3_r   <= pts2_r;

      nn4_r    <= nn4_nxt;
      em4_r    <= em4_nxt;
      eneg4_r  <= eneg4_nxt;
      eq4_r    <= eq3_r;
      w4_r     <= w3_r;
      pts4_r   <= pts3_r;
      nzero4_r <= nzero3_r;
      sel_s4_r <= sel_s3_r;
      sel_e4_r <= sel_e3_r;

      s5_r     <= s5_nxt;
      n2_5_r   <= n2_5_nxt;
      nn5_r    <= nn4_r;
      em5_r    <= em4_r;
      eneg5_r  <= eneg4_r;
      eq5_r    <= eq4_r;
      pts5_r   <= pts4_r;
      nzero5_r <= nzero4_r;
      sel_s5_r <= sel_s4_r;
      sel_e5_r <= sel_e4_r;

      pm6_r    <= pm6_nxt;
      pneg6_r  <= pneg6_nxt;
      n2_6_r   <= n2_5_r;
      em6_r    <= em5_r;
      eneg6_r  <= eneg5_r;
      eq6_r    <= eq5_r;
      pts6_r   <= pts5_r;
      nzero6_r <= nzero5_r;
      sel_s6_r <= sel_s5_r;
      sel_e6_r <= sel_e5_r;
    end
  end

  assign dvi.em    = em6_r;
  assign dvi.eneg  = eneg6_r;
  assign dvi.eq    = eq6_r;
  assign dvi.pm    = pm6_r;
  assign dvi.pneg  = pneg6_r;
  assign dvi.n2    = n2_6_r;
  assign side.pts   = pts6_r;
  assign side.nzero = nzero6_r;
  assign side.sel_s = sel_s6_r;
  assign side.sel_e = sel_e6_r;

endmodule

`default_nettype wire

[src/tcp_back.sv]
// ----------------------------------------------------------------------------
// tcp_back
// Inside test, edge choice and result select after the dividers.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_back (
  input  logic                               clk,
  input  logic                               en,
  input  tcp_pkg::side_t                     side,
  input  logic [2:0][tcp_pkg::Q_W-1:0]       qp,
  input  logic [2:0][2:0][tcp_pkg::Q_W-1:0]  qe,
  output tcp_pkg::result_t                   res
);

  localparam int PT_W   = tcp_pkg::PT_W;
  localparam int TD_W   = tcp_pkg::TD_W;
  localparam int XRAW_W = tcp_pkg::XRAW_W;
  localparam int XN_W   = tcp_pkg::XN_W;
  localparam int XP_W   = tcp_pkg::XP_W;
  localparam int XS_W   = tcp_pkg::XS_W;
  localparam int MD_W   = tcp_pkg::MD_W;
  localparam int SH_W   = tcp_pkg::SH_W;

  // E1: projected point and edge points
  logic [2:0][PT_W-1:0]      q1_r, q1_nxt;
  logic [2:0][2:0][PT_W-1:0] cp1_r, cp1_nxt;
  tcp_pkg::pts_t             pts1_r;
  logic                      nzero1_r;
  // E2: vertex offsets, edge offsets
  logic [2:0][2:0][TD_W-1:0] t2_r, t2_nxt, dd2_r, dd2_nxt;
  logic [2:0][PT_W-1:0]      q2_r;
  logic [2:0][2:0][PT_W-1:0] cp2_r;
  logic                      nzero2_r;
  // E3: raw crosses, squared distances
  logic [2:0][2:0][XRAW_W-1:0] xr3_r, xr3_nxt;
  logic [2:0][MD_W-1:0]      m3_r, m3_nxt;
  logic [2:0][PT_W-1:0]      q3_r;
  logic [2:0][2:0][PT_W-1:0] cp3_r;
  logic                      nzero3_r;
  // E4: cross scale, edge pick
  logic [2:0][SH_W-1:0]      xk4_r, xk4_nxt;
  logic [2:0][PT_W-1:0]      pick4_r, pick4_nxt;
  tcp_pkg::region_t          preg4_r, preg4_nxt;
  logic [2:0][2:0][XRAW_W-1:0] xr4_r;
  logic [2:0][PT_W-1:0]      q4_r;
  logic                      nzero4_r;
  // E5: scaled crosses
  logic [2:0][2:0][XN_W-1:0] xn5_r, xn5_nxt;
  logic [2:0][PT_W-1:0]      pick5_r, q5_r;
  tcp_pkg::region_t          preg5_r;
  logic                      nzero5_r;
  // E6: sign products
  logic [2:0][XP_W-1:0]      pyz6_r, pyz6_nxt, pxz6_r, pxz6_nxt;
  logic [2:0][PT_W-1:0]      pick6_r, q6_r;
  tcp_pkg::region_t          preg6_r;
  logic                      nzero6_r;

  always_comb begin
    int en_i;
    for (int i = 0; i < 3; i++) begin
      q1_nxt[i] = PT_W'($signed(side.pts[tcp_pkg::PP][i])) - PT_W'($signed(qp[i]));
    end
    for (int e = 0; e < 3; e++) begin
      en_i = (e == 2) ? 0 : e + 1;
      for (int i = 0; i < 3; i++) begin
        if (side.sel_s[e]) begin
          cp1_nxt[e][i] = PT_W'($signed(side.pts[e][i]));
        end else if (side.sel_e[e]) begin
          cp1_nxt[e][i] = PT_W'($signed(side.pts[en_i][i]));
        end else begin
          cp1_nxt[e][i] = PT_W'($signed(side.pts[e][i])) + PT_W'($signed(qe[e][i]));
        end
      end
    end
  end

  always_comb begin
    for (int v = 0; v < 3; v++) begin
      for (int i = 0; i < 3; i++) begin
        t2_nxt[v][i]  = TD_W'($signed(pts1_r[v][i])) - TD_W'($signed(q1_r[i]));
        dd2_nxt[v][i] = TD_W'($signed(pts1_r[tcp_pkg::PP][i])) - TD_W'($signed(cp1_r[v][i]));
      end
    end
  end

  always_comb begin
    int u;
    int w;
    int j;
    int k;
    logic signed [MD_W:0] acc;
    for (int v = 0; v < 3; v++) begin
      u = (v == 2) ? 0 : v + 1;
      w = (v == 0) ? 2 : v - 1;
      for (int i = 0; i < 3; i++) begin
        j = (i == 2) ? 0 : i + 1;
        k = (i == 0) ? 2 : i - 1;
        xr3_nxt[v][i] = XRAW_W'($signed(t2_r[u][j])) * XRAW_W'($signed(t2_r[w][k]))
                      - XRAW_W'($signed(t2_r[u][k])) * XRAW_W'($signed(t2_r[w][j]));
      end
    end
    for (int e = 0; e < 3; e++) begin
      acc = '0;
      for (int i = 0; i < 3; i++) begin
        acc = acc + (MD_W+1)'($signed(dd2_r[e][i])) * (MD_W+1)'($signed(dd2_r[e][i]));
      end
      m3_nxt[e] = MD_W'(acc);
    end
  end

  always_comb begin
    logic [63:0] m;
    logic [63:0] mx;
    for (int v = 0; v < 3; v++) begin
      mx = '0;
      for (int i = 0; i < 3; i++) begin
        m = tcp_pkg::mag64(64'($signed(xr3_r[v][i])));
        if (m > mx) mx = m;
      end
      xk4_nxt[v] = tcp_pkg::fit_shift(mx, tcp_pkg::XFIT_BITS);
    end
    // any tie falls through to edge CA
    priority if (m3_r[0] < m3_r[1] && m3_r[0] < m3_r[2]) begin
      pick4_nxt = cp3_r[0];
      preg4_nxt = tcp_pkg::REG_AB;
    end else if (m3_r[1] < m3_r[0] && m3_r[1] < m3_r[2]) begin
      pick4_nxt = cp3_r[1];
      preg4_nxt = tcp_pkg::REG_BC;
    end else begin
      pick4_nxt = cp3_r[2];
      preg4_nxt = tcp_pkg::REG_CA;
    end
  end

  always_comb begin
    for (int v = 0; v < 3; v++) begin
      for (int i = 0; i < 3; i++) begin
        xn5_nxt[v][i] = XN_W'(tcp_pkg::tshift(64'($signed(xr4_r[v][i])), xk4_r[v]));
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pyz6_nxt[i] = XP_W'($signed(xn5_r[1][i])) * XP_W'($signed(xn5_r[2][i]));
      pxz6_nxt[i] = XP_W'($signed(xn5_r[0][i])) * XP_W'($signed(xn5_r[2][i]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q1_r     <= q1_nxt;
      cp1_r    <= cp1_nxt;
      pts1_r   <= side.pts;
      nzero1_r <= side.nzero;

      t2_r     <= t2_nxt;
      dd2_r    <= dd2_nxt;
      q2_r     <= q1_r;
      cp2_r    <= cp1_r;
      nzero2_r <= nzero1_r;

      xr3_r    <= xr3_nxt;
      m3_r     <= m3_nxt;
      q3_r     <= q2_r;
      cp3_r    <= cp2_r;
      nzero3_r <= nzero2_r;

      xk4_r    <= xk4_nxt;
      pick4_r  <= pick4_nxt;
      preg4_r  <= preg4_nxt;
      xr4_r    <= xr3_r;
      q4_r     <= q3_r;
      nzero4_r <= nzero3_r;

      xn5_r    <= xn5_nxt;
      pick5_r  <= pick4_r;
      preg5_r  <= preg4_r;
      q5_r     <= q4_r;
      nzero5_r <= nzero4_r;

      pyz6_r   <= pyz6_nxt;
      pxz6_r   <= pxz6_nxt;
      pick6_r  <= pick5_r;
      preg6_r  <= preg5_r;
      q6_r     <= q5_r;
      nzero6_r <= nzero5_r;
    end
  end

  always_comb begin
    logic signed [XS_W-1:0] syz;
    logic signed [XS_W-1:0] sxz;
    logic                   in_tri;
    syz = '0;
    sxz = '0;
    for (int i = 0; i < 3; i++) begin
      syz = syz + XS_W'($signed(pyz6_r[i]));
      sxz = sxz + XS_W'($signed(pxz6_r[i]));
    end
    in_tri = !nzero6_r && (syz >= 0) && (sxz >= 0);
    for (int i = 0; i < 3; i++) begin
      res.pt[i] = in_tri ? tcp_pkg::sat_coord($signed(q6_r[i]))
                         : tcp_pkg::sat_coord($signed(pick6_r[i]));
    end
    res.region = in_tri ? tcp_pkg::REG_INTERIOR : preg6_r;
  end

endmodule

`default_nettype wire

[src/triangle_closest_point.sv]
// Throughput: one transaction per cycle; the whole pipeline holds only while a
// result sits in the output register and out_stall is high.
// Depth is set by the 18-stage divider (one quotient bit per stage) plus six
// front and six back stages and the output register.
// Reset (rst_n low, synchronous) clears the valid bits only; data registers keep junk.
// ----------------------------------------------------------------------------
// triangle_closest_point
// Closest point of triangle ABC to query P: plane projection with an inside
// test, falling back to the nearest clamped edge point.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_closest_point (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [tcp_pkg::CW-1:0]     in_vertex_a_x,
  input  logic signed [tcp_pkg::CW-1:0]     in_vertex_a_y,
  input  logic signed [tcp_pkg::CW-1:0]     in_vertex_a_z,
  input  logic signed [tcp_pkg::CW-1:0]     in_vertex_b_x,
  input  logic signed [tcp_pkg::CW-1:0]     in_vertex_b_y,
  input  logic signed [tcp_pkg::CW-1:0]     in_vertex_b_z,
  input  logic signed [tcp_pkg::CW-1:0]     in_vertex_c_x,
  input  logic signed [tcp_pkg::CW-1:0]     in_vertex_c_y,
  input  logic signed [tcp_pkg::CW-1:0]     in_vertex_c_z,
  input  logic signed [tcp_pkg::CW-1:0]     in_query_x,
  input  logic signed [tcp_pkg::CW-1:0]     in_query_y,
  input  logic signed [tcp_pkg::CW-1:0]     in_query_z,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [tcp_pkg::CW-1:0]     out_nearest_x,
  output logic signed [tcp_pkg::CW-1:0]     out_nearest_y,
  output logic signed [tcp_pkg::CW-1:0]     out_nearest_z,
  output logic [1:0]                        out_region
);

  localparam int PIPE_DEPTH = tcp_pkg::PIPE_DEPTH;
  localparam int QB         = tcp_pkg::DQ_BITS;
  localparam int Q_W        = tcp_pkg::Q_W;
  localparam int DD_W       = tcp_pkg::DD_W;

  logic                            en;
  logic [PIPE_DEPTH-1:0]           vld_r;
  logic                            out_valid_r;
  tcp_pkg::result_t                res;
  tcp_pkg::result_t                res_r;
  tcp_pkg::pts_t                   pts;
  tcp_pkg::div_in_t                dvi;
  tcp_pkg::side_t                  side;
  tcp_pkg::side_t                  sd_r [QB];
  logic [2:0][Q_W-1:0]             qp;
  logic [2:0][2:0][Q_W-1:0]        qe;
  logic [2:0][DD_W-1:0]            eden;

  // Advance everything unless a finished result is being held.
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  assign pts[tcp_pkg::PA][0] = in_vertex_a_x;
  assign pts[tcp_pkg::PA][1] = in_vertex_a_y;
  assign pts[tcp_pkg::PA][2] = in_vertex_a_z;
  assign pts[tcp_pkg::PB][0] = in_vertex_b_x;
  assign pts[tcp_pkg::PB][1] = in_vertex_b_y;
  assign pts[tcp_pkg::PB][2] = in_vertex_b_z;
  assign pts[tcp_pkg::PC][0] = in_vertex_c_x;
  assign pts[tcp_pkg::PC][1] = in_vertex_c_y;
  assign pts[tcp_pkg::PC][2] = in_vertex_c_z;
  assign pts[tcp_pkg::PP][0] = in_query_x;
  assign pts[tcp_pkg::PP][1] = in_query_y;
  assign pts[tcp_pkg::PP][2] = in_query_z;

  // Front: normal, its scaling, dot products and the dividend magnitudes.
  tcp_front u_front (
    .clk  (clk),
    .en   (en),
    .pts  (pts),
    .dvi  (dvi),
    .side (side)
  );

  // Projection quotients: (N_i * s) / |N|^2.
  for (genvar i = 0; i < 3; i++) begin : g_pdiv
    tcp_div u_div (
      .clk (clk),
      .en  (en),
      .num (dvi.pm[i]),
      .den (dvi.n2),
      .neg (dvi.pneg[i]),
      .quo (qp[i])
    );
  end

  // Edge quotients: (l_i * d) / q for each of AB, BC, CA.
  for (genvar e = 0; e < 3; e++) begin : g_edge
    assign eden[e] = DD_W'(dvi.eq[e]);
    for (genvar i = 0; i < 3; i++) begin : g_ediv
      tcp_div u_div (
        .clk (clk),
        .en  (en),
        .num (dvi.em[e][i]),
        .den (eden[e]),
        .neg (dvi.eneg[e][i]),
        .quo (qe[e][i])
      );
    end
  end

  // Carry vertices and decision flags alongside the divider stages.
  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[0] <= side;
      for (int j = 1; j < QB; j++) begin
        sd_r[j] <= sd_r[j-1];
      end
    end
  end

  // Back: inside test, nearest edge, final select and saturation.
  tcp_back u_back (
    .clk  (clk),
    .en   (en),
    .side (sd_r[QB-1]),
    .qp   (qp),
    .qe   (qe),
    .res  (res)
  );

  // Valid bits travel with the data; drop nothing while held.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[PIPE_DEPTH-2:0], in_valid};
      out_valid_r <= vld_r[PIPE_DEPTH-1];
    end
  end

  // Output register: hold the result until the transaction completes.
  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_nearest_x = $signed(res_r.pt[0]);
  assign out_nearest_y = $signed(res_r.pt[1]);
  assign out_nearest_z = $signed(res_r.pt[2]);
  assign out_region    = res_r.region;

  a_hold_pipe : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> $stable(vld_r))
    else $error("pipeline valid bits moved while the output was held");

  a_free_accept : assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> !in_stall)
    else $error("input stalled with an empty output register");

  a_enter : assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |=> (vld_r[0] == $past(in_valid)))
    else $error("accepted transaction not tracked in the first stage");

  a_leave : assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |=> (out_valid_r == $past(vld_r[PIPE_DEPTH-1])))
    else $error("last stage did not reach the output register");

endmodule

`default_nettype wire
